### sv/pgr_pkg.sv
// Shared types, latencies and the arctangent table of the pose-graph edge residual core.
`default_nettype none
package pgr_pkg;

    // Pipeline depths of the iterative units
    localparam int ATAN_STEPS   = 17;
    localparam int SQRT_BITS    = 32;
    localparam int DIV_BITS     = 32;
    localparam int FRONT_STAGES = 8;
    localparam int ROT_LAT      = FRONT_STAGES + SQRT_BITS + 1 + ATAN_STEPS + 3 + DIV_BITS + 1;
    localparam int TRN_LAT      = 6;
    localparam int TRN_DLY      = ROT_LAT - TRN_LAT;

    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [31:0]        SAT_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0]        SAT_MIN     = 32'h8000_0000;

    // One input beat
    typedef struct packed {
        logic [63:0] first_rotation;
        logic [31:0] first_pos_x;
        logic [31:0] first_pos_y;
        logic [31:0] first_pos_z;
        logic [63:0] second_rotation;
        logic [31:0] second_pos_x;
        logic [31:0] second_pos_y;
        logic [31:0] second_pos_z;
        logic [63:0] measured_rotation;
        logic [31:0] measured_pos_x;
        logic [31:0] measured_pos_y;
        logic [31:0] measured_pos_z;
    } t_edge;

    // Rotation residual and small-angle flag
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        tiny;
    } t_rot_res;

    // Translation residual
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_trn_res;

    // Normalized error quaternion riding along the square root
    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] w;
        logic        tiny;
    } t_vec_carry;

    // Vector part and norm riding along the CORDIC
    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] n;
        logic        tiny;
    } t_ang_carry;

    // Divisor and per-lane flags riding along the divider
    typedef struct packed {
        logic [31:0] n;
        logic [2:0]  sgn;
        logic [2:0]  ovf;
        logic        tiny;
    } t_div_carry;

    // atan(2^-i) in Q16.16, rounded to nearest
    function automatic logic signed [19:0] atan_q16(input logic [4:0] idx);
        logic signed [19:0] v;
        unique case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### sv/pose_graph_edge_residual_core.sv
// Top level of the pose-graph edge residual core: stream ports, valid pipeline, alignment.
// One pose-graph edge goes in per beat and one six-component residual comes out per beat.
// The depth is set by the 32-stage square root of the rotation-error norm,
// the 17-stage CORDIC for atan2 and the 32-stage divider that scales the axis by
// theta / |v|; the translation path is 6 stages and is delayed to line up. A new edge is
// taken every cycle while the output is taken; when the output beat waits, the whole
// pipeline holds and nothing is dropped. m_axis_tuser is set when the rotation error is
// too small to give an axis, and the rotation residual is then zero.
`default_nettype none
module pose_graph_edge_residual_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_rotation, first_pos_x/y/z, second_rotation, second_pos_x/y/z,
    // measured_rotation, measured_pos_x/y/z (from bit 0 up)
    input  logic [479:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rotation_error_x/y/z, translation_error_x/y/z (from bit 0 up)
    output logic [191:0] m_axis_tdata,
    // tiny_angle
    output logic [0:0]   m_axis_tuser
);

    localparam int LAT = pgr_pkg::ROT_LAT;
    localparam int DLY = pgr_pkg::TRN_DLY;

    pgr_pkg::t_edge    w_edge;
    pgr_pkg::t_rot_res w_rot;
    pgr_pkg::t_trn_res w_trn;
    logic              w_en;
    logic [LAT-1:0]    r_vld;
    pgr_pkg::t_trn_res r_tdl [0:DLY-1];

    // Unpack the input beat
    assign w_edge.first_rotation    = s_axis_tdata[63:0];
    assign w_edge.first_pos_x       = s_axis_tdata[95:64];
    assign w_edge.first_pos_y       = s_axis_tdata[127:96];
    assign w_edge.first_pos_z       = s_axis_tdata[159:128];
    assign w_edge.second_rotation   = s_axis_tdata[223:160];
    assign w_edge.second_pos_x      = s_axis_tdata[255:224];
    assign w_edge.second_pos_y      = s_axis_tdata[287:256];
    assign w_edge.second_pos_z      = s_axis_tdata[319:288];
    assign w_edge.measured_rotation = s_axis_tdata[383:320];
    assign w_edge.measured_pos_x    = s_axis_tdata[415:384];
    assign w_edge.measured_pos_y    = s_axis_tdata[447:416];
    assign w_edge.measured_pos_z    = s_axis_tdata[479:448];

    // Pipeline advances unless the output beat is stuck
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    pgr_rot u_rot (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_edge (w_edge),
        .o_res  (w_rot)
    );

    pgr_trn u_trn (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_edge (w_edge),
        .o_res  (w_trn)
    );

    // Valid bits travel beside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // Delay line aligning the translation result with the rotation result
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdl[0] <= w_trn;
            for (int i = 1; i < DLY; i++) begin
                r_tdl[i] <= r_tdl[i-1];
            end
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = {r_tdl[DLY-1].z, r_tdl[DLY-1].y, r_tdl[DLY-1].x,
                            w_rot.z, w_rot.y, w_rot.x};
    assign m_axis_tuser  = w_rot.tiny;

    // Small-angle beats carry a zero rotation residual
    a_tiny_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[95:0] == 96'd0)
        else $error("tiny_angle beat with nonzero rotation residual");

    // A held pipeline keeps every valid bit
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved while stalled");

    // An accepted beat enters the first stage
    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");

    // Reset empties the pipeline
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

### sv/pgr_rot.sv
// Rotation residual pipeline: error quaternion, block normalize, square root, CORDIC, divide.
`default_nettype none
module pgr_rot (
    input  logic              i_clk,
    input  logic              i_en,
    input  pgr_pkg::t_edge    i_edge,
    output pgr_pkg::t_rot_res o_res
);

    // ---------------- stage 1: p = conj(qi) * qj ----------------
    logic signed [15:0] w_qi [4];
    logic signed [15:0] w_qj [4];
    logic signed [15:0] w_qm [4];
    logic signed [33:0] n_p [4];
    logic signed [33:0] r_p [4];
    logic [63:0]        r_qm;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_qi[k] = i_edge.first_rotation[16*k +: 16];
            w_qj[k] = i_edge.second_rotation[16*k +: 16];
        end
        n_p[3] = w_qi[3]*w_qj[3] + w_qi[0]*w_qj[0] + w_qi[1]*w_qj[1] + w_qi[2]*w_qj[2];
        n_p[0] = w_qi[3]*w_qj[0] - w_qj[3]*w_qi[0] - (w_qi[1]*w_qj[2] - w_qi[2]*w_qj[1]);
        n_p[1] = w_qi[3]*w_qj[1] - w_qj[3]*w_qi[1] - (w_qi[2]*w_qj[0] - w_qi[0]*w_qj[2]);
        n_p[2] = w_qi[3]*w_qj[2] - w_qj[3]*w_qi[2] - (w_qi[0]*w_qj[1] - w_qi[1]*w_qj[0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_qm <= i_edge.measured_rotation;
        end
    end

    // ---------------- stage 2: e = conj(qm) * p ----------------
    logic signed [51:0] n_e [4];
    logic signed [51:0] r_e [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_qm[k] = r_qm[16*k +: 16];
        end
        n_e[3] = w_qm[3]*r_p[3] + w_qm[0]*r_p[0] + w_qm[1]*r_p[1] + w_qm[2]*r_p[2];
        n_e[0] = w_qm[3]*r_p[0] - r_p[3]*w_qm[0] - (w_qm[1]*r_p[2] - w_qm[2]*r_p[1]);
        n_e[1] = w_qm[3]*r_p[1] - r_p[3]*w_qm[1] - (w_qm[2]*r_p[0] - w_qm[0]*r_p[2]);
        n_e[2] = w_qm[3]*r_p[2] - r_p[3]*w_qm[2] - (w_qm[0]*r_p[1] - w_qm[1]*r_p[0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= n_e;
        end
    end

    // ---------------- stage 3: magnitudes, OR of all (same bit length as max) --------
    logic [51:0] n_mag [4];
    logic [51:0] r_mag3 [4];
    logic [3:0]  n_neg;
    logic [3:0]  r_neg3;
    logic [51:0] n_orv;
    logic [51:0] r_orv;

    always_comb begin
        n_orv = '0;
        for (int k = 0; k < 4; k++) begin
            n_neg[k] = r_e[k][51];
            n_mag[k] = r_e[k][51] ? 52'(-r_e[k]) : 52'(r_e[k]);
            n_orv    = n_orv | n_mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag3 <= n_mag;
            r_neg3 <= n_neg;
            r_orv  <= n_orv;
        end
    end

    // ---------------- stage 4: leading one per byte group ----------------
    logic [55:0] w_orp;
    logic [6:0]  n_gnz;
    logic [2:0]  n_gidx [7];
    logic [6:0]  r_gnz;
    logic [2:0]  r_gidx [7];
    logic [51:0] r_mag4 [4];
    logic [3:0]  r_neg4;

    assign w_orp = {4'd0, r_orv};

    always_comb begin
        for (int g = 0; g < 7; g++) begin
            n_gnz[g]  = |w_orp[8*g +: 8];
            n_gidx[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (w_orp[8*g + b]) begin
                    n_gidx[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gnz  <= n_gnz;
            r_gidx <= n_gidx;
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
        end
    end

    // ---------------- stage 5: bit length of the largest magnitude ----------------
    logic [5:0]  n_len;
    logic [5:0]  r_len;
    logic [51:0] r_mag5 [4];
    logic [3:0]  r_neg5;

    always_comb begin
        n_len = 6'd0;
        for (int g = 0; g < 7; g++) begin
            if (r_gnz[g]) begin
                n_len = 6'(8*g) + 6'(r_gidx[g]) + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len  <= n_len;
            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
        end
    end

    // ---------------- stage 6: block shift, top magnitude into [2^30, 2^31) ----------
    logic [51:0] w_sh [4];
    logic [30:0] n_vn [4];
    logic [31:0] n_ve [4];
    logic        n_tiny6;
    logic [30:0] r_vn [3];
    logic [31:0] r_ve [4];
    logic        r_tiny6;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_len > 6'd31) begin
                w_sh[k] = r_mag5[k] >> (r_len - 6'd31);
            end else begin
                w_sh[k] = r_mag5[k] << (6'd31 - r_len);
            end
            n_vn[k] = w_sh[k][30:0];
            n_ve[k] = r_neg5[k] ? (32'd0 - {1'b0, n_vn[k]}) : {1'b0, n_vn[k]};
        end
        n_tiny6 = (r_len == 6'd0) || ((n_vn[0] | n_vn[1] | n_vn[2]) == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_vn[k] <= n_vn[k];
            end
            r_ve    <= n_ve;
            r_tiny6 <= n_tiny6;
        end
    end

    // ---------------- stage 7: squares of the vector part ----------------
    logic [61:0]         r_sq [3];
    pgr_pkg::t_vec_carry r_vc7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 62'(r_vn[k]) * 62'(r_vn[k]);
            end
            r_vc7.vx   <= r_ve[0];
            r_vc7.vy   <= r_ve[1];
            r_vc7.vz   <= r_ve[2];
            r_vc7.w    <= r_ve[3];
            r_vc7.tiny <= r_tiny6;
        end
    end

    // ---------------- stage 8 and square root: one result bit a stage ----------------
    logic [31:0]         r_sr   [0:pgr_pkg::SQRT_BITS];
    logic [63:0]         r_srem [0:pgr_pkg::SQRT_BITS];
    pgr_pkg::t_vec_carry r_sc   [0:pgr_pkg::SQRT_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0]   <= 32'd0;
            r_srem[0] <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_sc[0]   <= r_vc7;
        end
    end

    for (genvar i = 0; i < pgr_pkg::SQRT_BITS; i++) begin : g_sqrt
        localparam int B = pgr_pkg::SQRT_BITS - 1 - i;
        logic [65:0] w_trial;

        // (r + 2^B)^2 <= s  <=>  s - r^2 >= r*2^(B+1) + 2^(2B)
        assign w_trial = ({34'd0, r_sr[i]} << (B + 1)) + (66'd1 << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({2'b00, r_srem[i]} >= w_trial) begin
                    r_sr[i+1]   <= r_sr[i] | (32'd1 << B);
                    r_srem[i+1] <= r_srem[i] - w_trial[63:0];
                end else begin
                    r_sr[i+1]   <= r_sr[i];
                    r_srem[i+1] <= r_srem[i];
                end
                r_sc[i+1] <= r_sc[i];
            end
        end
    end

    // ---------------- CORDIC entry: pre-rotate by -pi/2 for negative w ----------------
    logic signed [35:0]  r_cx [0:pgr_pkg::ATAN_STEPS];
    logic signed [35:0]  r_cy [0:pgr_pkg::ATAN_STEPS];
    logic signed [19:0]  r_cz [0:pgr_pkg::ATAN_STEPS];
    pgr_pkg::t_ang_carry r_cc [0:pgr_pkg::ATAN_STEPS];
    logic signed [31:0]  w_w;
    logic [31:0]         w_n;

    assign w_w = r_sc[pgr_pkg::SQRT_BITS].w;
    assign w_n = r_sr[pgr_pkg::SQRT_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_w[31]) begin
                r_cx[0] <= 36'(w_w);
                r_cy[0] <= $signed({4'd0, w_n});
                r_cz[0] <= 20'sd0;
            end else begin
                r_cx[0] <= $signed({4'd0, w_n});
                r_cy[0] <= -36'(w_w);
                r_cz[0] <= pgr_pkg::HALF_PI_Q16;
            end
            r_cc[0].vx   <= r_sc[pgr_pkg::SQRT_BITS].vx;
            r_cc[0].vy   <= r_sc[pgr_pkg::SQRT_BITS].vy;
            r_cc[0].vz   <= r_sc[pgr_pkg::SQRT_BITS].vz;
            r_cc[0].n    <= w_n;
            r_cc[0].tiny <= r_sc[pgr_pkg::SQRT_BITS].tiny;
        end
    end

    // ---------------- CORDIC vectoring, one micro-rotation a stage ----------------
    for (genvar k = 0; k < pgr_pkg::ATAN_STEPS; k++) begin : g_cordic
        logic signed [35:0] w_xs;
        logic signed [35:0] w_ys;

        assign w_xs = r_cx[k] >>> k;
        assign w_ys = r_cy[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[k][35]) begin
                    r_cx[k+1] <= r_cx[k] + w_ys;
                    r_cy[k+1] <= r_cy[k] - w_xs;
                    r_cz[k+1] <= r_cz[k] + pgr_pkg::atan_q16(5'(k));
                end else begin
                    r_cx[k+1] <= r_cx[k] - w_ys;
                    r_cy[k+1] <= r_cy[k] + w_xs;
                    r_cz[k+1] <= r_cz[k] - pgr_pkg::atan_q16(5'(k));
                end
                r_cc[k+1] <= r_cc[k];
            end
        end
    end

    // ---------------- theta * v_k ----------------
    logic signed [20:0]  w_theta;
    logic signed [31:0]  w_vc [3];
    logic signed [52:0]  r_prod [3];
    logic [31:0]         r_pn;
    logic                r_ptiny;

    assign w_theta = $signed({r_cz[pgr_pkg::ATAN_STEPS], 1'b0});
    assign w_vc[0] = r_cc[pgr_pkg::ATAN_STEPS].vx;
    assign w_vc[1] = r_cc[pgr_pkg::ATAN_STEPS].vy;
    assign w_vc[2] = r_cc[pgr_pkg::ATAN_STEPS].vz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= w_theta * w_vc[k];
            end
            r_pn    <= r_cc[pgr_pkg::ATAN_STEPS].n;
            r_ptiny <= r_cc[pgr_pkg::ATAN_STEPS].tiny;
        end
    end

    // ---------------- rounding offset: |prod| + n/2 ----------------
    logic [52:0] w_abs [3];
    logic [53:0] r_num [3];
    logic [2:0]  r_nsgn;
    logic [31:0] r_nn;
    logic        r_ntiny;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = r_prod[k][52] ? 53'(-r_prod[k]) : 53'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k]  <= {1'b0, w_abs[k]} + 54'(r_pn >> 1);
                r_nsgn[k] <= r_prod[k][52];
            end
            r_nn    <= r_pn;
            r_ntiny <= r_ptiny;
        end
    end

    // ---------------- overflow check, then restoring divide a bit a stage -------------
    logic [53:0]         r_drem [0:pgr_pkg::DIV_BITS][3];
    logic [31:0]         r_dq   [0:pgr_pkg::DIV_BITS][3];
    pgr_pkg::t_div_carry r_dc   [0:pgr_pkg::DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_drem[0][k]  <= r_num[k];
                r_dq[0][k]    <= 32'd0;
                r_dc[0].ovf[k] <= {10'd0, r_num[k]} >= {r_nn, 32'd0};
            end
            r_dc[0].n    <= r_nn;
            r_dc[0].sgn  <= r_nsgn;
            r_dc[0].tiny <= r_ntiny;
        end
    end

    for (genvar i = 0; i < pgr_pkg::DIV_BITS; i++) begin : g_div
        localparam int B = pgr_pkg::DIV_BITS - 1 - i;
        logic [63:0] w_trial;

        assign w_trial = {32'd0, r_dc[i].n} << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    if ({10'd0, r_drem[i][k]} >= w_trial) begin
                        r_drem[i+1][k] <= r_drem[i][k] - w_trial[53:0];
                        r_dq[i+1][k]   <= r_dq[i][k] | (32'd1 << B);
                    end else begin
                        r_drem[i+1][k] <= r_drem[i][k];
                        r_dq[i+1][k]   <= r_dq[i][k];
                    end
                end
                r_dc[i+1] <= r_dc[i];
            end
        end
    end

    // ---------------- sign, saturation, small-angle zeroing ----------------
    logic [31:0]       n_rv [3];
    pgr_pkg::t_rot_res r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_dc[pgr_pkg::DIV_BITS].tiny) begin
                n_rv[k] = 32'd0;
            end else if (r_dc[pgr_pkg::DIV_BITS].ovf[k]) begin
                n_rv[k] = r_dc[pgr_pkg::DIV_BITS].sgn[k] ? pgr_pkg::SAT_MIN : pgr_pkg::SAT_MAX;
            end else if (r_dc[pgr_pkg::DIV_BITS].sgn[k]) begin
                n_rv[k] = (r_dq[pgr_pkg::DIV_BITS][k] > pgr_pkg::SAT_MIN) ? pgr_pkg::SAT_MIN
                        : (32'd0 - r_dq[pgr_pkg::DIV_BITS][k]);
            end else begin
                n_rv[k] = r_dq[pgr_pkg::DIV_BITS][k][31] ? pgr_pkg::SAT_MAX
                        : r_dq[pgr_pkg::DIV_BITS][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x    <= n_rv[0];
            r_out.y    <= n_rv[1];
            r_out.z    <= n_rv[2];
            r_out.tiny <= r_dc[pgr_pkg::DIV_BITS].tiny;
        end
    end

    assign o_res = r_out;

endmodule
`default_nettype wire

### sv/pgr_trn.sv
// Translation residual pipeline: R(conj qi) * (tj - ti) - tm, rounded and saturated.
`default_nettype none
module pgr_trn (
    input  logic              i_clk,
    input  logic              i_en,
    input  pgr_pkg::t_edge    i_edge,
    output pgr_pkg::t_trn_res o_res
);

    // ---------------- T1: difference and quaternion products ----------------
    logic signed [15:0] w_qx, w_qy, w_qz, w_qw;
    logic signed [31:0] w_ti [3];
    logic signed [31:0] w_tj [3];
    logic signed [32:0] r_d [3];
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    logic [95:0]        r_tm [0:4];

    assign w_qx = i_edge.first_rotation[15:0];
    assign w_qy = i_edge.first_rotation[31:16];
    assign w_qz = i_edge.first_rotation[47:32];
    assign w_qw = i_edge.first_rotation[63:48];
    assign w_ti[0] = i_edge.first_pos_x;
    assign w_ti[1] = i_edge.first_pos_y;
    assign w_ti[2] = i_edge.first_pos_z;
    assign w_tj[0] = i_edge.second_pos_x;
    assign w_tj[1] = i_edge.second_pos_y;
    assign w_tj[2] = i_edge.second_pos_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= w_tj[k] - w_ti[k];
            end
            r_xx <= w_qx * w_qx;
            r_yy <= w_qy * w_qy;
            r_zz <= w_qz * w_qz;
            r_xy <= w_qx * w_qy;
            r_zw <= w_qz * w_qw;
            r_xz <= w_qx * w_qz;
            r_yw <= w_qy * w_qw;
            r_yz <= w_qy * w_qz;
            r_xw <= w_qx * w_qw;
            r_tm[0] <= {i_edge.measured_pos_z, i_edge.measured_pos_y, i_edge.measured_pos_x};
        end
    end

    // ---------------- T2: matrix entries in Q2.30, split of the difference ----------
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    logic signed [33:0] r_m [9];
    logic signed [16:0] r_dh [3];
    logic [15:0]        r_dl [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= ONE_Q30 - 34'sd2 * (r_yy + r_zz);
            r_m[1] <= 34'sd2 * (r_xy + r_zw);
            r_m[2] <= 34'sd2 * (r_xz - r_yw);
            r_m[3] <= 34'sd2 * (r_xy - r_zw);
            r_m[4] <= ONE_Q30 - 34'sd2 * (r_xx + r_zz);
            r_m[5] <= 34'sd2 * (r_yz + r_xw);
            r_m[6] <= 34'sd2 * (r_xz + r_yw);
            r_m[7] <= 34'sd2 * (r_yz - r_xw);
            r_m[8] <= ONE_Q30 - 34'sd2 * (r_xx + r_yy);
            for (int k = 0; k < 3; k++) begin
                r_dh[k] <= r_d[k][32:16];
                r_dl[k] <= r_d[k][15:0];
            end
            r_tm[1] <= r_tm[0];
        end
    end

    // ---------------- T3: partial products, high and low halves ----------------
    logic signed [50:0] r_ph [9];
    logic signed [50:0] r_pl [9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_ph[i] <= r_m[i] * r_dh[i % 3];
                r_pl[i] <= r_m[i] * $signed({1'b0, r_dl[i % 3]});
            end
            r_tm[2] <= r_tm[1];
        end
    end

    // ---------------- T4: row sums ----------------
    logic signed [52:0] r_sh [3];
    logic signed [52:0] r_sl [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_sh[r] <= r_ph[3*r] + r_ph[3*r+1] + r_ph[3*r+2];
                r_sl[r] <= r_pl[3*r] + r_pl[3*r+1] + r_pl[3*r+2];
            end
            r_tm[3] <= r_tm[2];
        end
    end

    // ---------------- T5: recombine, round half up to Q16.16 ----------------
    logic signed [69:0] w_tot [3];
    logic signed [39:0] r_res [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_tot[r] = $signed({r_sh[r], 16'd0}) + r_sl[r] + 70'sd536870912;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_res[r] <= w_tot[r][69:30];
            end
            r_tm[4] <= r_tm[3];
        end
    end

    // ---------------- T6: subtract measured translation, saturate ----------------
    logic signed [31:0] w_tmc [3];
    logic signed [40:0] w_dif [3];
    logic [31:0]        n_out [3];
    pgr_pkg::t_trn_res  r_out;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_tmc[r] = r_tm[4][32*r +: 32];
            w_dif[r] = r_res[r] - w_tmc[r];
            if (w_dif[r] > 41'sd2147483647) begin
                n_out[r] = pgr_pkg::SAT_MAX;
            end else if (w_dif[r] < -41'sd2147483648) begin
                n_out[r] = pgr_pkg::SAT_MIN;
            end else begin
                n_out[r] = w_dif[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x <= n_out[0];
            r_out.y <= n_out[1];
            r_out.z <= n_out[2];
        end
    end

    assign o_res = r_out;

endmodule
`default_nettype wire
